FILE: design/fetg_pkg.sv
`default_nettype none

package fetg_pkg;

   localparam int STEP_BITS = 23;
   localparam int AMP_BITS  = 7;
   localparam int CSR_BITS  = 23;
   localparam int SINE_BITS = 16;
   localparam int MAG_BITS  = 15;
   localparam int PROD_BITS = 24;
   localparam int POS_BITS  = 16;
   localparam int PHASE_OUT_BITS = 24;

   typedef logic [1:0]           csr_index_type;
   typedef logic [CSR_BITS-1:0]  csr_data_type;
   typedef logic [STEP_BITS-1:0] step_type;
   typedef logic [AMP_BITS-1:0]  amp_type;
   typedef logic signed [SINE_BITS-1:0] sine_type;
   typedef logic signed [POS_BITS-1:0]  pos_type;

   localparam csr_index_type CSR_PHASE_STEP  = 2'd0;
   localparam csr_index_type CSR_X_AMPLITUDE = 2'd1;
   localparam csr_index_type CSR_Y_AMPLITUDE = 2'd2;

   localparam step_type PHASE_STEP_RESET  = 23'd133511;
   localparam amp_type  X_AMPLITUDE_RESET = 7'd50;
   localparam amp_type  Y_AMPLITUDE_RESET = 7'd25;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned MAG_MAX     = 64'd32767;

   // quarter-wave entry k of 2^qbits, unsigned Q0.15, Taylor series in Q30
   function automatic logic [MAG_BITS-1:0] rom_entry(input int unsigned k,
                                                      input int unsigned qbits);
      longint unsigned kk;
      longint unsigned half;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      kk   = 64'(k);
      half = (64'd1 << qbits) >> 1;
      x    = (kk * HALF_PI_Q30 + half) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;   sum = sum - term;
      term = ((term * x2) >> 30) / 20;  sum = sum + term;
      term = ((term * x2) >> 30) / 42;  sum = sum - term;
      term = ((term * x2) >> 30) / 72;  sum = sum + term;
      term = ((term * x2) >> 30) / 110; sum = sum - term;
      term = ((term * x2) >> 30) / 156; sum = sum + term;
      term = ((term * x2) >> 30) / 210; sum = sum - term;
      term = ((term * x2) >> 30) / 272; sum = sum + term;
      term = ((term * x2) >> 30) / 342; sum = sum - term;
      r = (sum * MAG_MAX + (64'd1 << 29)) >> 30;
      if (r > MAG_MAX) begin
         r = MAG_MAX;
      end
      return r[MAG_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: design/fetg_sine_rom.sv
`default_nettype none

module fetg_sine_rom #(
   parameter int TABLE_ADDR_BITS = 10
) (
   input  wire logic                       clock,
   input  wire logic                       enable,
   input  wire logic [TABLE_ADDR_BITS-1:0] addr_a,
   input  wire logic [TABLE_ADDR_BITS-1:0] addr_b,
   output fetg_pkg::sine_type              sine_a,
   output fetg_pkg::sine_type              sine_b
);
   import fetg_pkg::*;

   localparam int QBITS = TABLE_ADDR_BITS - 2;
   localparam int DEPTH = (1 << QBITS) + 1;
   localparam logic [QBITS:0] FULL_Q = {1'b1, QBITS'(0)};

   logic [MAG_BITS-1:0] rom_table [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      localparam logic [MAG_BITS-1:0] ENTRY = rom_entry(k, QBITS);
      assign rom_table[k] = ENTRY;
   end

   // mirror odd quadrants
   function automatic logic [QBITS:0] fold(input logic [TABLE_ADDR_BITS-1:0] addr);
      logic [QBITS:0] low;
      low = {1'b0, addr[QBITS-1:0]};
      if (addr[TABLE_ADDR_BITS-2]) begin
         fold = FULL_Q - low;
      end else begin
         fold = low;
      end
   endfunction

   logic [QBITS:0]      idx_a, idx_b;
   logic [MAG_BITS-1:0] mag_a_ff, mag_b_ff;
   logic                neg_a_ff, neg_b_ff;

   assign idx_a = fold(addr_a);
   assign idx_b = fold(addr_b);

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_a_ff <= rom_table[idx_a];
         mag_b_ff <= rom_table[idx_b];
         neg_a_ff <= addr_a[TABLE_ADDR_BITS-1];
         neg_b_ff <= addr_b[TABLE_ADDR_BITS-1];
      end
   end

   assign sine_a = neg_a_ff ? -sine_type'({1'b0, mag_a_ff}) : sine_type'({1'b0, mag_a_ff});
   assign sine_b = neg_b_ff ? -sine_type'({1'b0, mag_b_ff}) : sine_type'({1'b0, mag_b_ff});

endmodule

`default_nettype wire

FILE: design/fetg_pos_scale.sv
`default_nettype none

module fetg_pos_scale (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire fetg_pkg::amp_type  amp,
   input  wire fetg_pkg::sine_type sine,
   output fetg_pkg::pos_type      pos
);
   import fetg_pkg::*;

   logic signed [AMP_BITS:0]    amp_s;
   logic signed [PROD_BITS-1:0] product_in, product_ff;
   logic signed [PROD_BITS-1:0] rounded;

   assign amp_s      = signed'({1'b0, amp});
   assign product_in = PROD_BITS'(amp_s) * PROD_BITS'(sine);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   // round half up to Q8.8
   assign rounded = (product_ff + PROD_BITS'(64)) >>> 7;
   assign pos     = rounded[POS_BITS-1:0];

endmodule

`default_nettype wire

FILE: design/figure_eight_trajectory_generator_unit.sv
// A word accepted with tick high passes the phase, table read, scale and output
// stages to rsp. Throughput: one word per cycle unless rsp_stall holds it.
// A stalled result backs up the pipeline; bubbles still fill behind it.
// Reset: synchronous, clears phase to zero, empties the pipeline and loads
// phase_step 133511, x_amplitude 50, y_amplitude 25.
`default_nettype none

module figure_eight_trajectory_generator_unit #(
   parameter int PHASE_BITS      = 24,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_tick,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output fetg_pkg::pos_type            rsp_x_pos,
   output fetg_pkg::pos_type            rsp_y_pos,
   output fetg_pkg::sine_type           rsp_quat_w,
   output fetg_pkg::sine_type           rsp_quat_z,
   output logic [23:0]                  rsp_phase_out,
   input  wire logic                    csr_write,
   input  wire fetg_pkg::csr_index_type csr_index,
   input  wire fetg_pkg::csr_data_type  csr_data
);
   import fetg_pkg::*;

   localparam int SUM_BITS = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;
   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, (PHASE_BITS-2)'(0)};

   // configuration
   step_type phase_step_ff;
   amp_type  x_amp_ff, y_amp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         x_amp_ff      <= X_AMPLITUDE_RESET;
         y_amp_ff      <= Y_AMPLITUDE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PHASE_STEP:  phase_step_ff <= csr_data[STEP_BITS-1:0];
            CSR_X_AMPLITUDE: x_amp_ff      <= csr_data[AMP_BITS-1:0];
            CSR_Y_AMPLITUDE: y_amp_ff      <= csr_data[AMP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, rsp_valid_in;
   logic adv1, adv2, adv3, adv_out;
   logic accept, fire;

   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv3      = !v3_ff || adv_out;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && adv1;
   assign fire      = accept && req_tick;

   assign v1_in        = adv1    ? fire  : v1_ff;
   assign v2_in        = adv2    ? v1_ff : v2_ff;
   assign v3_in        = adv3    ? v2_ff : v3_ff;
   assign rsp_valid_in = adv_out ? v3_ff : rsp_valid_ff;

   // phase accumulator
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [SUM_BITS-1:0]   phase_sum;

   assign phase_sum = SUM_BITS'(phase_ff) + SUM_BITS'(phase_step_ff);
   assign phase_in  = fire ? phase_sum[PHASE_BITS-1:0] : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: phase of this point
   logic [PHASE_BITS-1:0] p1_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         p1_ff <= phase_ff;
      end
   end

   function automatic logic [TABLE_ADDR_BITS-1:0] angle_addr(input logic [PHASE_BITS-1:0] a);
      logic [PHASE_BITS+TABLE_ADDR_BITS-1:0] ext;
      ext = {a, TABLE_ADDR_BITS'(0)};
      return ext[PHASE_BITS+TABLE_ADDR_BITS-1 -: TABLE_ADDR_BITS];
   endfunction

   logic [PHASE_BITS-1:0] ang_x, ang_y, ang_w, ang_z;

   assign ang_x = p1_ff;
   assign ang_y = p1_ff << 1;
   assign ang_z = p1_ff >> 1;
   assign ang_w = (p1_ff >> 1) + QUARTER_TURN;

   // stage 2: table read
   sine_type sin_x, sin_y, sin_w, sin_z;
   logic [PHASE_OUT_BITS-1:0] p2_ff, p3_ff;

   fetg_sine_rom #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_rom_xy (
      .clock  (clock),
      .enable (adv2),
      .addr_a (angle_addr(ang_x)),
      .addr_b (angle_addr(ang_y)),
      .sine_a (sin_x),
      .sine_b (sin_y)
   );

   fetg_sine_rom #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_rom_wz (
      .clock  (clock),
      .enable (adv2),
      .addr_a (angle_addr(ang_w)),
      .addr_b (angle_addr(ang_z)),
      .sine_a (sin_w),
      .sine_b (sin_z)
   );

   always_ff @(posedge clock) begin
      if (adv2) begin
         p2_ff <= PHASE_OUT_BITS'(p1_ff);
      end
   end

   // stage 3: amplitude scaling
   pos_type  pos_x, pos_y;
   sine_type w3_ff, z3_ff;

   fetg_pos_scale u_scale_x (
      .clock  (clock),
      .enable (adv3),
      .amp    (x_amp_ff),
      .sine   (sin_x),
      .pos    (pos_x)
   );

   fetg_pos_scale u_scale_y (
      .clock  (clock),
      .enable (adv3),
      .amp    (y_amp_ff),
      .sine   (sin_y),
      .pos    (pos_y)
   );

   always_ff @(posedge clock) begin
      if (adv3) begin
         w3_ff <= sin_w;
         z3_ff <= sin_z;
         p3_ff <= p2_ff;
      end
   end

   // output word
   pos_type  x_out_ff, y_out_ff;
   sine_type w_out_ff, z_out_ff;
   logic [PHASE_OUT_BITS-1:0] p_out_ff;

   always_ff @(posedge clock) begin
      if (adv_out && v3_ff) begin
         x_out_ff <= pos_x;
         y_out_ff <= pos_y;
         w_out_ff <= w3_ff;
         z_out_ff <= z3_ff;
         p_out_ff <= p3_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_pos     = x_out_ff;
   assign rsp_y_pos     = y_out_ff;
   assign rsp_quat_w    = w_out_ff;
   assign rsp_quat_z    = z_out_ff;
   assign rsp_phase_out = p_out_ff;

endmodule

`default_nettype wire

FILE: design/fetg_checker.sv
`default_nettype none

module fetg_checker #(
   parameter int PHASE_BITS = 24
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_x_pos,
   input wire logic [15:0] rsp_quat_w,
   input wire logic [15:0] rsp_quat_z,
   input wire logic [23:0] rsp_phase_out
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input only backs up behind a stalled word
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req stalled while output free");

   // half angle lies in the upper half plane
   a_quat_z_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_quat_z[15])
      else $error("quat_z negative");

   a_quat_w_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (PHASE_BITS == 24) && !rsp_phase_out[23]) |-> !rsp_quat_w[15])
      else $error("quat_w negative in first half turn");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_x_pos)
                                    && $stable(rsp_phase_out)))
      else $error("stalled word changed");

endmodule

bind figure_eight_trajectory_generator_unit fetg_checker #(.PHASE_BITS(PHASE_BITS))
   u_fetg_checker (
      .clock         (clock),
      .reset         (reset),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_x_pos     (rsp_x_pos),
      .rsp_quat_w    (rsp_quat_w),
      .rsp_quat_z    (rsp_quat_z),
      .rsp_phase_out (rsp_phase_out)
   );

`default_nettype wire
